// ----- rtl/tod_pkg.sv -----
// types, constants and helpers shared by the time of day counter
package tod_pkg;

	localparam int unsigned HOURS_W  = 5;
	localparam int unsigned MINUTE_W = 6;
	localparam int unsigned SECOND_W = 6;
	localparam int unsigned AMOUNT_W = 17;

	localparam logic [HOURS_W-1:0]  DAY_HOURS      = 5'd24;
	localparam logic [MINUTE_W-1:0] HOUR_MINUTES   = 6'd60;
	localparam logic [SECOND_W-1:0] MINUTE_SECONDS = 6'd60;
	localparam logic [16:0]         HOUR_SECS      = 17'd3600;

	// reciprocal constants: x / 225 = (x * 9321) >> 21 for x < 8192,
	// x / 15 = (x * 4370) >> 16 for x < 900
	localparam logic [13:0] HOUR_RECIP = 14'd9321;
	localparam int unsigned HOUR_SHIFT = 21;
	localparam logic [12:0] MIN_RECIP  = 13'd4370;
	localparam int unsigned MIN_SHIFT  = 16;

	typedef enum logic [2:0] {
		KIND_LOAD     = 3'd0,
		KIND_PRE_INC  = 3'd1,
		KIND_PRE_DEC  = 3'd2,
		KIND_POST_INC = 3'd3,
		KIND_POST_DEC = 3'd4,
		KIND_ADD      = 3'd5,
		KIND_SUB      = 3'd6
	} kind_t;

	typedef struct packed {
		kind_t                kind;
		logic [HOURS_W-1:0]   load_hours;
		logic [MINUTE_W-1:0]  load_minutes;
		logic [SECOND_W-1:0]  load_seconds;
		logic [AMOUNT_W-1:0]  amount;
	} req_t;

	typedef struct packed {
		logic [HOURS_W-1:0]   out_hours;
		logic [MINUTE_W-1:0]  out_minutes;
		logic [SECOND_W-1:0]  out_seconds;
		logic                 time_valid;
	} rsp_t;

	typedef struct packed {
		logic [HOURS_W-1:0]   hours;
		logic [MINUTE_W-1:0]  minutes;
		logic [SECOND_W-1:0]  seconds;
	} hms_t;

	function automatic logic time_ok(input hms_t t);
		return (t.hours < DAY_HOURS) && (t.minutes < HOUR_MINUTES) &&
			(t.seconds < MINUTE_SECONDS);
	endfunction

endpackage

// ----- rtl/time_of_day_counter.sv -----
// 24-hour hh:mm:ss time of day counter with load, step, add and subtract requests
//
// The block holds one hours:minutes:seconds time, reset to 00:00:00. Each
// request carries a kind: load stores the given time as is (even out of
// range), the four step kinds move the time by one second up or down and
// report either the new time (prefix) or the time before the step
// (postfix), and add / subtract move the time by amount seconds modulo one
// day. While the stored time is out of range, every kind but load leaves
// it alone and the result reports it with time_valid low. Every request
// gives exactly one result. The block takes one request per clock cycle,
// sustained while rsp_stall stays low; a request passes the input register,
// two amount stages and the result register before its result appears on
// rsp. The first two stages split amount into hours, minutes and seconds
// with constant reciprocal multiplies, and the third applies the request
// to the stored time with a short combinational carry / borrow chain across
// the three digits, which is what lets back to back requests see each
// other's result. Each stage stalls only when full and blocked, so bubbles
// are squeezed out and requests keep flowing into empty stages while a
// finished result waits on rsp_stall.
module time_of_day_counter (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  tod_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output tod_pkg::rsp_t  rsp
);
	import tod_pkg::*;

	// stage 2: amount split into whole hours and leftover seconds
	typedef struct packed {
		kind_t              kind;
		hms_t               load;
		logic [HOURS_W-1:0] amt_hours;
		logic [11:0]        amt_rem;
	} st2_t;

	// stage 3: operand in hh:mm:ss and its direction
	typedef struct packed {
		kind_t kind;
		hms_t  load;
		hms_t  opd;
		logic  opd_sub;
	} st3_t;

	// pipeline control
	logic  valid_s1, valid_s2, valid_s3, rsp_valid_q;
	logic  rdy_s1, rdy_s2, rdy_s3, rdy_out, adv_s3;
	req_t  req_s1;
	st2_t  st_s2, st2_d;
	st3_t  st_s3, st3_d;
	rsp_t  rsp_q, rsp_d;

	// stored time
	hms_t  time_q, time_d;
	logic  time_ok_now;

	// each stage takes new data when empty or when its downstream moves
	assign rdy_out   = !rsp_valid_q || !rsp_stall;
	assign rdy_s3    = !valid_s3 || rdy_out;
	assign rdy_s2    = !valid_s2 || rdy_s3;
	assign rdy_s1    = !valid_s1 || rdy_s2;
	assign adv_s3    = valid_s3 && rdy_out;
	assign req_stall = !rdy_s1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// stage 1 -> 2: amount / 3600 by reciprocal, then reduce hours mod 24
	logic [12:0] amt_div16;
	logic [26:0] hq_prod;
	logic [5:0]  hq;
	logic [16:0] hq_secs;
	logic [16:0] rem_full;

	always_comb begin
		amt_div16 = req_s1.amount[16:4];
		hq_prod   = 27'(amt_div16) * 27'(HOUR_RECIP);
		hq        = hq_prod[HOUR_SHIFT +: 6];
		hq_secs   = 17'(hq) * HOUR_SECS;
		rem_full  = req_s1.amount - hq_secs;

		st2_d.kind = req_s1.kind;
		st2_d.load = '{hours: req_s1.load_hours, minutes: req_s1.load_minutes,
			seconds: req_s1.load_seconds};
		st2_d.amt_rem = rem_full[11:0];
		// 86400 is exactly 24 hours, so only the hour digit wraps
		if (hq >= 6'(DAY_HOURS)) begin
			st2_d.amt_hours = HOURS_W'(hq - 6'(DAY_HOURS));
		end else begin
			st2_d.amt_hours = hq[HOURS_W-1:0];
		end
	end

	// stage 2 -> 3: leftover / 60 by reciprocal, build the operand
	logic [9:0]  rem_div4;
	logic [22:0] mq_prod;
	logic [5:0]  mq;
	logic [11:0] sec_full;

	always_comb begin
		rem_div4 = st_s2.amt_rem[11:2];
		mq_prod  = 23'(rem_div4) * 23'(MIN_RECIP);
		mq       = mq_prod[MIN_SHIFT +: 6];
		sec_full = st_s2.amt_rem - (12'(mq) * 12'(MINUTE_SECONDS));

		st3_d.kind    = st_s2.kind;
		st3_d.load    = st_s2.load;
		st3_d.opd_sub = 1'b0;
		st3_d.opd     = '{hours: st_s2.amt_hours, minutes: mq, seconds: sec_full[5:0]};
		case (st_s2.kind) inside
			KIND_PRE_INC, KIND_POST_INC: begin
				st3_d.opd = '{hours: '0, minutes: '0, seconds: 6'd1};
			end
			KIND_PRE_DEC, KIND_POST_DEC: begin
				st3_d.opd     = '{hours: '0, minutes: '0, seconds: 6'd1};
				st3_d.opd_sub = 1'b1;
			end
			KIND_SUB: begin
				st3_d.opd_sub = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// stage 3: mixed radix add / subtract against the stored time
	logic [6:0] s_sum, m_sum, s_dif, m_dif;
	logic [5:0] h_sum, h_dif;
	logic       s_cy, m_cy, s_bw, m_bw;
	hms_t       t_add, t_sub, t_new;

	always_comb begin
		time_ok_now = time_ok(time_q);

		s_sum = {1'b0, time_q.seconds} + {1'b0, st_s3.opd.seconds};
		s_cy  = s_sum >= 7'(MINUTE_SECONDS);
		t_add.seconds = s_cy ? SECOND_W'(s_sum - 7'(MINUTE_SECONDS)) : s_sum[5:0];
		m_sum = {1'b0, time_q.minutes} + {1'b0, st_s3.opd.minutes} + 7'(s_cy);
		m_cy  = m_sum >= 7'(HOUR_MINUTES);
		t_add.minutes = m_cy ? MINUTE_W'(m_sum - 7'(HOUR_MINUTES)) : m_sum[5:0];
		h_sum = {1'b0, time_q.hours} + {1'b0, st_s3.opd.hours} + 6'(m_cy);
		t_add.hours = (h_sum >= 6'(DAY_HOURS)) ?
			HOURS_W'(h_sum - 6'(DAY_HOURS)) : h_sum[4:0];

		s_dif = {1'b0, time_q.seconds} - {1'b0, st_s3.opd.seconds};
		s_bw  = s_dif[6];
		t_sub.seconds = s_bw ? SECOND_W'(s_dif + 7'(MINUTE_SECONDS)) : s_dif[5:0];
		m_dif = {1'b0, time_q.minutes} - {1'b0, st_s3.opd.minutes} - 7'(s_bw);
		m_bw  = m_dif[6];
		t_sub.minutes = m_bw ? MINUTE_W'(m_dif + 7'(HOUR_MINUTES)) : m_dif[5:0];
		h_dif = {1'b0, time_q.hours} - {1'b0, st_s3.opd.hours} - 6'(m_bw);
		t_sub.hours = h_dif[5] ? HOURS_W'(h_dif + 6'(DAY_HOURS)) : h_dif[4:0];

		t_new = st_s3.opd_sub ? t_sub : t_add;
	end

	// next stored time and the reported result
	always_comb begin
		time_d = time_q;
		rsp_d  = '{out_hours: time_q.hours, out_minutes: time_q.minutes,
			out_seconds: time_q.seconds, time_valid: time_ok_now};
		case (st_s3.kind) inside
			KIND_LOAD: begin
				time_d = st_s3.load;
				rsp_d  = '{out_hours: st_s3.load.hours, out_minutes: st_s3.load.minutes,
					out_seconds: st_s3.load.seconds, time_valid: time_ok(st_s3.load)};
			end
			KIND_PRE_INC, KIND_PRE_DEC, KIND_ADD, KIND_SUB: begin
				if (time_ok_now) begin
					time_d = t_new;
					rsp_d  = '{out_hours: t_new.hours, out_minutes: t_new.minutes,
						out_seconds: t_new.seconds, time_valid: 1'b1};
				end
			end
			KIND_POST_INC, KIND_POST_DEC: begin
				// postfix reports the time before the step
				if (time_ok_now) begin
					time_d = t_new;
				end
			end
			default: begin
				// unused kind: report the stored time untouched
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			rsp_valid_q <= 1'b0;
			time_q      <= '0;
		end else begin
			if (rdy_s1) begin
				valid_s1 <= req_valid;
			end
			if (rdy_s2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy_s3) begin
				valid_s3 <= valid_s2;
			end
			if (rdy_out) begin
				rsp_valid_q <= valid_s3;
			end
			if (adv_s3) begin
				time_q <= time_d;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (rdy_s1 && req_valid) begin
			req_s1 <= req;
		end
		if (rdy_s2 && valid_s1) begin
			st_s2 <= st2_d;
		end
		if (rdy_s3 && valid_s2) begin
			st_s3 <= st3_d;
		end
		if (adv_s3) begin
			rsp_q <= rsp_d;
		end
	end

`ifndef SYNTH
	// only a load can take a legal stored time out of range
	a_ok_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s3 && st_s3.kind != KIND_LOAD && time_ok_now) |=> time_ok_now)
		else $error("legal time went out of range without a load");

	// the stored time moves only when stage 3 hands off a request
	a_time_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv_s3 |=> $stable(time_q))
		else $error("stored time changed without a request");

	// out-of-range time is frozen for every kind but load
	a_bad_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s3 && !time_ok_now && st_s3.kind != KIND_LOAD) |=> $stable(time_q))
		else $error("out-of-range time was modified");

	// an arithmetic request on a legal time always reports a legal time
	a_arith_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s3 && time_ok_now && (st_s3.kind == KIND_PRE_INC ||
		st_s3.kind == KIND_PRE_DEC || st_s3.kind == KIND_POST_INC ||
		st_s3.kind == KIND_POST_DEC || st_s3.kind == KIND_ADD ||
		st_s3.kind == KIND_SUB)) |=> (rsp_valid && rsp.time_valid))
		else $error("arithmetic request on legal time reported invalid");
`endif

endmodule

// ----- test/time_of_day_counter_tb.sv -----
// testbench for the time of day counter: directed table, random requests, scoreboard
`timescale 1ns / 100ps

module time_of_day_counter_tb;
	import tod_pkg::*;

	// seconds in a day, an hour and a minute, for the clock predictor
	localparam int unsigned DAY_LEN    = 86400;
	localparam int unsigned HOUR_LEN   = 3600;
	localparam int unsigned MINUTE_LEN = 60;

	// the one kind code that the package leaves unnamed
	localparam logic [2:0] KIND_UNUSED = 3'd7;

	localparam int RANDOM_REQUESTS = 1450;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int HOLD_OFF_AFTER  = 500;	// results seen before the long receiver stall
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int SETTLE_CYCLES   = 8;	// quiet cycles after the drain, to catch stray results
	localparam int REPORT_LIMIT    = 10;

	// amounts around the day boundary and the top of the field
	localparam int unsigned EDGE_AMOUNTS [8] = '{0, 1, 60, 3600, 86399, 86400, 86401, 131071};

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_TOGGLE
	} stall_mode_t;

	// one row of the directed part: the request, and where it can be read off
	// at a glance, the result typed in by hand
	typedef struct packed {
		req_t cmd;
		logic typed;
		rsp_t want;
	} plan_row_t;

	localparam int PLAN_ROWS = 25;
	localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
		// wrap both ways straight out of reset, prefix and postfix
		'{'{KIND_PRE_DEC,  5'd0,  6'd0,  6'd0,  17'd0},      1'b1, '{5'd23, 6'd59, 6'd59, 1'b1}},
		'{'{KIND_PRE_INC,  5'd0,  6'd0,  6'd0,  17'd0},      1'b1, '{5'd0,  6'd0,  6'd0,  1'b1}},
		'{'{KIND_POST_DEC, 5'd31, 6'd63, 6'd63, 17'h1ffff},  1'b1, '{5'd0,  6'd0,  6'd0,  1'b1}},
		'{'{KIND_POST_INC, 5'd0,  6'd0,  6'd0,  17'd0},      1'b1, '{5'd23, 6'd59, 6'd59, 1'b1}},
		'{'{KIND_LOAD,     5'd23, 6'd59, 6'd59, 17'h1ffff},  1'b1, '{5'd23, 6'd59, 6'd59, 1'b1}},
		'{'{KIND_PRE_INC,  5'd0,  6'd0,  6'd0,  17'd0},      1'b1, '{5'd0,  6'd0,  6'd0,  1'b1}},
		'{'{KIND_LOAD,     5'd12, 6'd34, 6'd56, 17'd0},      1'b1, '{5'd12, 6'd34, 6'd56, 1'b1}},
		// add and subtract across the day boundary, amounts at the extremes
		'{'{KIND_ADD,      5'd0,  6'd0,  6'd0,  17'h1ffff},  1'b0, '0},
		'{'{KIND_SUB,      5'd0,  6'd0,  6'd0,  17'd86400},  1'b0, '0},
		'{'{KIND_SUB,      5'd0,  6'd0,  6'd0,  17'd0},      1'b0, '0},
		'{'{KIND_ADD,      5'd0,  6'd0,  6'd0,  17'd86399},  1'b0, '0},
		'{'{KIND_SUB,      5'd0,  6'd0,  6'd0,  17'h1ffff},  1'b0, '0},
		'{'{kind_t'(KIND_UNUSED), 5'd31, 6'd63, 6'd63, 17'h1ffff}, 1'b0, '0},
		'{'{KIND_ADD,      5'd0,  6'd0,  6'd0,  17'd86401},  1'b0, '0},
		// out of range time: everything but load leaves it alone, flag low
		'{'{KIND_LOAD,     5'd31, 6'd63, 6'd63, 17'd0},      1'b1, '{5'd31, 6'd63, 6'd63, 1'b0}},
		'{'{KIND_PRE_INC,  5'd0,  6'd0,  6'd0,  17'd0},      1'b1, '{5'd31, 6'd63, 6'd63, 1'b0}},
		'{'{KIND_POST_DEC, 5'd0,  6'd0,  6'd0,  17'd0},      1'b1, '{5'd31, 6'd63, 6'd63, 1'b0}},
		'{'{KIND_ADD,      5'd0,  6'd0,  6'd0,  17'd1},      1'b1, '{5'd31, 6'd63, 6'd63, 1'b0}},
		'{'{KIND_SUB,      5'd0,  6'd0,  6'd0,  17'h1ffff},  1'b1, '{5'd31, 6'd63, 6'd63, 1'b0}},
		'{'{kind_t'(KIND_UNUSED), 5'd0, 6'd0, 6'd0, 17'd0},  1'b1, '{5'd31, 6'd63, 6'd63, 1'b0}},
		// each field just past its range on its own
		'{'{KIND_LOAD,     5'd24, 6'd0,  6'd0,  17'd0},      1'b1, '{5'd24, 6'd0,  6'd0,  1'b0}},
		'{'{KIND_LOAD,     5'd0,  6'd60, 6'd0,  17'd0},      1'b1, '{5'd0,  6'd60, 6'd0,  1'b0}},
		'{'{KIND_LOAD,     5'd0,  6'd0,  6'd60, 17'd0},      1'b1, '{5'd0,  6'd0,  6'd60, 1'b0}},
		// back to a legal time, amount ignored by load, then borrow past midnight
		'{'{KIND_LOAD,     5'd0,  6'd0,  6'd0,  17'h1ffff},  1'b1, '{5'd0,  6'd0,  6'd0,  1'b1}},
		'{'{KIND_SUB,      5'd0,  6'd0,  6'd0,  17'd1},      1'b1, '{5'd23, 6'd59, 6'd59, 1'b1}}
	};

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	// predictor state: the time the block should hold after every accepted request
	hms_t stored_time;
	// results still owed by the block, oldest first
	rsp_t expected_times [$];

	int failures;
	int results_seen;
	int burst_left;
	int cycle_count;
	rsp_t want_rsp;

	time_of_day_counter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic bit legal_time(input hms_t t);
		return t.hours < 24 && t.minutes < 60 && t.seconds < 60;
	endfunction

	// apply one request to the predicted time and return the result it owes
	function automatic rsp_t advance_clock(input req_t r);
		hms_t prior;
		int unsigned secs;
		int unsigned amt;
		bit report_prior;
		rsp_t res;
		prior = stored_time;
		secs = prior.hours * HOUR_LEN + prior.minutes * MINUTE_LEN + prior.seconds;
		amt = r.amount % DAY_LEN;
		report_prior = 1'b0;
		if (r.kind == KIND_LOAD) begin
			stored_time = '{hours: r.load_hours, minutes: r.load_minutes,
				seconds: r.load_seconds};
		end else if (legal_time(prior)) begin
			case (r.kind)
				KIND_PRE_INC: secs = (secs + 1) % DAY_LEN;
				KIND_PRE_DEC: secs = (secs + DAY_LEN - 1) % DAY_LEN;
				KIND_POST_INC: begin
					secs = (secs + 1) % DAY_LEN;
					report_prior = 1'b1;
				end
				KIND_POST_DEC: begin
					secs = (secs + DAY_LEN - 1) % DAY_LEN;
					report_prior = 1'b1;
				end
				KIND_ADD: secs = (secs + amt) % DAY_LEN;
				KIND_SUB: secs = (secs + DAY_LEN - amt) % DAY_LEN;
				default: ;
			endcase
			stored_time.hours   = 5'(secs / HOUR_LEN);
			stored_time.minutes = 6'((secs % HOUR_LEN) / MINUTE_LEN);
			stored_time.seconds = 6'(secs % MINUTE_LEN);
		end
		if (report_prior) begin
			res = '{out_hours: prior.hours, out_minutes: prior.minutes,
				out_seconds: prior.seconds, time_valid: 1'b1};
		end else begin
			res = '{out_hours: stored_time.hours, out_minutes: stored_time.minutes,
				out_seconds: stored_time.seconds, time_valid: legal_time(stored_time)};
		end
		return res;
	endfunction

	// mostly legal times and ordinary steps, with a share of out of range loads
	// so the invalid state is visited and left again
	function automatic req_t random_request();
		req_t r;
		int pick;
		r.kind         = KIND_LOAD;
		r.load_hours   = 5'($urandom);
		r.load_minutes = 6'($urandom);
		r.load_seconds = 6'($urandom);
		r.amount       = ($urandom_range(3) == 0) ? 17'(EDGE_AMOUNTS[$urandom_range(7)])
			: 17'($urandom);
		pick = $urandom_range(99);
		if (pick < 14) begin
			r.kind = KIND_LOAD;
			pick = $urandom_range(99);
			if (pick < 70) begin
				r.load_hours   = 5'($urandom_range(23));
				r.load_minutes = 6'($urandom_range(59));
				r.load_seconds = 6'($urandom_range(59));
			end else if (pick < 88) begin
				// just before a carry into minutes, hours or the next day
				r.load_hours   = ($urandom_range(1) == 0) ? 5'd23 : 5'($urandom_range(23));
				r.load_minutes = ($urandom_range(1) == 0) ? 6'd59 : 6'($urandom_range(59));
				r.load_seconds = ($urandom_range(1) == 0) ? 6'd59 : 6'd0;
			end
		end else if (pick < 26) r.kind = KIND_PRE_INC;
		else if (pick < 38) r.kind = KIND_PRE_DEC;
		else if (pick < 50) r.kind = KIND_POST_INC;
		else if (pick < 62) r.kind = KIND_POST_DEC;
		else if (pick < 78) r.kind = KIND_ADD;
		else if (pick < 95) r.kind = KIND_SUB;
		else r.kind = kind_t'(KIND_UNUSED);
		return r;
	endfunction

	// hold the request until it is taken, then log what it owes
	task automatic issue_request(input req_t r, input bit typed, input rsp_t want);
		rsp_t predicted;
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		predicted = advance_clock(r);
		expected_times.push_back(typed ? want : predicted);
	endtask

	// sender runs in bursts; a quarter of the bursts run straight into the next
	task automatic pace_sender();
		int gap;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic log_failure(input string msg);
		failures++;
		if (failures <= REPORT_LIMIT) $display("%s", msg);
	endtask

	// stimulus: reset, directed table, random requests, then drain and report
	initial begin
		int idx;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		stored_time = '0;
		failures = 0;
		burst_left = $urandom_range(1, 40);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (idx = 0; idx < PLAN_ROWS; idx++) begin
			issue_request(DIRECTED_PLAN[idx].cmd, DIRECTED_PLAN[idx].typed,
				DIRECTED_PLAN[idx].want);
			pace_sender();
		end
		for (idx = 0; idx < RANDOM_REQUESTS; idx++) begin
			issue_request(random_request(), 1'b0, '0);
			pace_sender();
		end
		req_valid <= 1'b0;

		// every owed result back, then a few quiet cycles to catch strays
		while (expected_times.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// receiver stall pattern, with one long hold-off so the pipeline backs up
	// into req_stall while the sender keeps offering
	initial begin
		int seg_len;
		stall_mode_t mode;
		bit held_off;
		held_off = 1'b0;
		rsp_stall <= 1'b0;
		forever begin
			if (!held_off && results_seen >= HOLD_OFF_AFTER) begin
				held_off = 1'b1;
				@(posedge clk);
				rsp_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			seg_len = $urandom_range(1, 60);
			mode = stall_mode_t'($urandom_range(3));
			repeat (seg_len) begin
				@(posedge clk);
				case (mode)
					STALL_NONE:   rsp_stall <= 1'b0;
					STALL_LIGHT:  rsp_stall <= ($urandom_range(9) < 3);
					STALL_HEAVY:  rsp_stall <= ($urandom_range(9) < 7);
					STALL_TOGGLE: rsp_stall <= ~rsp_stall;
					default:      rsp_stall <= 1'b0;
				endcase
			end
		end
	end

	// scoreboard: each result taken is compared with the oldest owed one
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			results_seen++;
			if (expected_times.size() == 0) begin
				log_failure($sformatf("unexpected result %0d:%0d:%0d valid %0b",
					rsp.out_hours, rsp.out_minutes, rsp.out_seconds, rsp.time_valid));
			end else begin
				want_rsp = expected_times.pop_front();
				if (rsp.out_hours !== want_rsp.out_hours ||
						rsp.out_minutes !== want_rsp.out_minutes ||
						rsp.out_seconds !== want_rsp.out_seconds ||
						rsp.time_valid !== want_rsp.time_valid) begin
					log_failure($sformatf(
						"result %0d: expected %0d:%0d:%0d valid %0b, got %0d:%0d:%0d valid %0b",
						results_seen, want_rsp.out_hours, want_rsp.out_minutes,
						want_rsp.out_seconds, want_rsp.time_valid, rsp.out_hours,
						rsp.out_minutes, rsp.out_seconds, rsp.time_valid));
				end
			end
		end
	end

	// watchdog
	initial begin
		cycle_count = 0;
		results_seen = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

endmodule

// ----- files.f -----
rtl/tod_pkg.sv
rtl/time_of_day_counter.sv
test/time_of_day_counter_tb.sv
